>>> hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_VIOL  = 2'd2
    } kind_t;

    localparam logic [3:0] OP_CLOSE   = 4'h8;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       last_of_frame;
        logic       now_closed;
    } result_t;

endpackage

>>> hw/rtl/websocket_frame_deframer_unit.sv
// WebSocket client-to-server frame deframer: top level.
// Takes one received byte per cycle on the input channel and gives at most one result
// per byte, in the cycle after the byte, through a single result register. A new byte
// is accepted every cycle unless the output side stalls a word held in that register.
// Header, length and key bytes are absorbed by the parser, but the last one of an
// empty or unmasked frame gives its result. Each payload byte comes out unmasked with
// its opcode and an end-of-frame mark. An unmasked frame or a close frame's end
// closes the block, after which all input is taken and dropped until reset.
module websocket_frame_deframer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [3:0] frame_opcode,
    output logic       last_of_frame,
    output logic       now_closed
);
    import wsd_pkg::*;

    logic    accept;
    logic    res_valid;
    logic    full;
    result_t res;
    result_t out_res;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    wsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .full      (full),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind          = out_res.kind;
    assign data_byte     = out_res.data_byte;
    assign frame_opcode  = out_res.frame_opcode;
    assign last_of_frame = out_res.last_of_frame;
    assign now_closed    = out_res.now_closed;

endmodule

>>> hw/rtl/wsd_parser.sv
// Frame header parser, mask-key capture and payload unmasking state.
module wsd_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    output logic            res_valid,
    output wsd_pkg::result_t res
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  held_opcode_reg, held_opcode_next;
    logic        mask_present_reg, mask_present_next;
    logic [63:0] bytes_remaining_reg, bytes_remaining_next;
    logic [3:0]  ext_len_left_reg, ext_len_left_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  key_index_reg, key_index_next;
    logic        conn_closed_reg, conn_closed_next;

    logic [3:0]  ext_dec;
    logic [63:0] bytes_dec;
    logic        len_done;
    logic        done_masked;
    logic [7:0]  key_byte;
    logic        is_close;

    assign ext_dec   = (ext_len_left_reg != 4'd0) ? ext_len_left_reg - 4'd1 : 4'd0;
    assign bytes_dec = bytes_remaining_reg - 64'd1;
    assign is_close  = (held_opcode_reg == OP_CLOSE);

    always_comb
    begin
        unique case (key_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next           = phase_reg;
        held_opcode_next     = held_opcode_reg;
        mask_present_next    = mask_present_reg;
        bytes_remaining_next = bytes_remaining_reg;
        ext_len_left_next    = ext_len_left_reg;
        mask_key_next        = mask_key_reg;
        key_index_next       = key_index_reg;
        conn_closed_next     = conn_closed_reg;
        len_done             = 1'b0;
        done_masked          = mask_present_reg;
        res_valid            = 1'b0;
        res.kind             = KIND_DATA;
        res.data_byte        = 8'd0;
        res.frame_opcode     = held_opcode_reg;
        res.last_of_frame    = 1'b0;
        res.now_closed       = 1'b0;

        if (accept && !conn_closed_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    mask_present_next    = in_byte[7];
                    done_masked          = in_byte[7];
                    bytes_remaining_next = 64'd0;
                    if (in_byte[6:0] == LEN_EXT16)
                    begin
                        ext_len_left_next = EXT16_BYTES;
                        phase_next        = PH_EXT;
                    end
                    else if (in_byte[6:0] == LEN_EXT64)
                    begin
                        ext_len_left_next = EXT64_BYTES;
                        phase_next        = PH_EXT;
                    end
                    else
                    begin
                        bytes_remaining_next = {57'd0, in_byte[6:0]};
                        len_done             = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    bytes_remaining_next = {bytes_remaining_reg[55:0], in_byte};
                    ext_len_left_next    = ext_dec;
                    len_done             = (ext_dec == 4'd0);
                end
                PH_KEY:
                begin
                    mask_key_next     = {mask_key_reg[23:0], in_byte};
                    ext_len_left_next = ext_dec;
                    if (ext_dec == 4'd0)
                    begin
                        key_index_next = 2'd0;
                        if (bytes_remaining_reg == 64'd0)
                        begin
                            // empty payload: one result ends the frame
                            phase_next        = PH_HDR0;
                            conn_closed_next  = is_close;
                            res_valid         = 1'b1;
                            res.kind          = KIND_EMPTY;
                            res.last_of_frame = 1'b1;
                            res.now_closed    = is_close;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    key_index_next       = key_index_reg + 2'd1;
                    bytes_remaining_next = bytes_dec;
                    res_valid            = 1'b1;
                    res.data_byte        = in_byte ^ key_byte;
                    if (bytes_dec == 64'd0)
                    begin
                        phase_next        = PH_HDR0;
                        conn_closed_next  = is_close;
                        res.last_of_frame = 1'b1;
                        res.now_closed    = is_close;
                    end
                end
                default:
                begin
                    held_opcode_next = in_byte[3:0];
                    phase_next       = PH_HDR1;
                end
            endcase

            // length complete: unmasked frame is a violation, else collect the key
            if (len_done)
            begin
                if (!done_masked)
                begin
                    conn_closed_next  = 1'b1;
                    phase_next        = PH_HDR0;
                    res_valid         = 1'b1;
                    res.kind          = KIND_VIOL;
                    res.last_of_frame = 1'b1;
                    res.now_closed    = 1'b1;
                end
                else
                begin
                    phase_next        = PH_KEY;
                    ext_len_left_next = KEY_BYTES;
                    mask_key_next     = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HDR0;
            held_opcode_reg     <= 4'd0;
            mask_present_reg    <= 1'b0;
            bytes_remaining_reg <= 64'd0;
            ext_len_left_reg    <= 4'd0;
            mask_key_reg        <= 32'd0;
            key_index_reg       <= 2'd0;
            conn_closed_reg     <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            held_opcode_reg     <= held_opcode_next;
            mask_present_reg    <= mask_present_next;
            bytes_remaining_reg <= bytes_remaining_next;
            ext_len_left_reg    <= ext_len_left_next;
            mask_key_reg        <= mask_key_next;
            key_index_reg       <= key_index_next;
            conn_closed_reg     <= conn_closed_next;
        end
    end

    closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        conn_closed_reg |=> conn_closed_reg)
        else $error("closed connection reopened");

    closing_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.now_closed |=> conn_closed_reg && phase_reg == PH_HDR0)
        else $error("closing result did not close");

    non_data_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind != KIND_DATA |-> res.last_of_frame && res.data_byte == 8'd0)
        else $error("empty or violation result malformed");

    no_result_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        conn_closed_reg |-> !res_valid)
        else $error("result produced while closed");

    key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_KEY |-> ext_len_left_reg <= KEY_BYTES && ext_len_left_reg != 4'd0)
        else $error("key byte count out of range");

endmodule

>>> hw/rtl/wsd_out_reg.sv
// Result register between the parser and the output channel.
module wsd_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  wsd_pkg::result_t res,
    input  logic             out_stall,
    output logic             full,
    output logic             out_valid,
    output wsd_pkg::result_t out_res
);
    import wsd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload only; hold while stalled
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign full      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> tb/websocket_frame_deframer_unit_test.sv
// Self-checking testbench for the WebSocket frame deframer: frame stimulus, predictor, checker.
`timescale 1ns / 100ps

module websocket_frame_deframer_unit_test;

    import wsd_pkg::*;

    typedef enum int {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    localparam int LINK_BYTES_WANTED = 850;
    localparam int CALM_TAIL_BYTES   = 120;
    localparam int LONG_HOLD_CYCLES  = 60;
    localparam int LONG_HOLD_AFTER   = 80;
    localparam int QUIET_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       last_of_frame;
    logic       now_closed;

    logic [7:0] link_bytes[$];
    result_t    results_due[$];

    bit         calm = 1'b0;
    bit         byte_taken = 1'b0;
    int         gap_left = 0;
    int         hold_left = 0;
    bit         long_hold_done = 1'b0;
    int         quiet_cycles = 0;
    int         fail_count = 0;
    int         results_checked = 0;
    int         payload_seen = 0;
    int         empty_seen = 0;
    int         viol_seen = 0;
    int         frames_built = 0;
    string      ending_name;

    // predictor state
    phase_t      ph = PH_HDR0;
    logic [3:0]  op = 4'h0;
    bit          masked = 1'b0;
    logic [63:0] remaining = 64'd0;
    logic [3:0]  count_left = 4'd0;
    logic [31:0] key = 32'd0;
    logic [1:0]  key_pos = 2'd0;
    bit          closed = 1'b0;

    websocket_frame_deframer_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .frame_opcode  (frame_opcode),
        .last_of_frame (last_of_frame),
        .now_closed    (now_closed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Append one word to the link stream.
    function automatic void queue_link_byte(input logic [7:0] b);
        link_bytes = {link_bytes, b};
    endfunction

    // Length is complete: an unmasked frame is a violation, else go collect the key.
    task automatic end_of_length(output bit got, output result_t r);
        got = 1'b0;
        r = '0;
        if (!masked)
        begin
            closed = 1'b1;
            ph = PH_HDR0;
            r.kind = KIND_VIOL;
            r.data_byte = 8'h00;
            r.frame_opcode = op;
            r.last_of_frame = 1'b1;
            r.now_closed = 1'b1;
            got = 1'b1;
        end
        else
        begin
            ph = PH_KEY;
            count_left = KEY_BYTES;
            key = 32'd0;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, output bit got, output result_t r);
        logic [7:0] kb;
        got = 1'b0;
        r = '0;
        if (closed)
            return;
        case (ph)
            PH_HDR1:
            begin
                masked = b[7];
                remaining = 64'd0;
                if (b[6:0] == LEN_EXT16)
                begin
                    count_left = EXT16_BYTES;
                    ph = PH_EXT;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    count_left = EXT64_BYTES;
                    ph = PH_EXT;
                end
                else
                begin
                    remaining = {57'd0, b[6:0]};
                    end_of_length(got, r);
                end
            end
            PH_EXT:
            begin
                remaining = {remaining[55:0], b};
                if (count_left != 4'd0)
                    count_left = count_left - 4'd1;
                if (count_left == 4'd0)
                    end_of_length(got, r);
            end
            PH_KEY:
            begin
                key = {key[23:0], b};
                if (count_left != 4'd0)
                    count_left = count_left - 4'd1;
                if (count_left == 4'd0)
                begin
                    key_pos = 2'd0;
                    if (remaining == 64'd0)
                    begin
                        ph = PH_HDR0;
                        if (op == OP_CLOSE)
                            closed = 1'b1;
                        r.kind = KIND_EMPTY;
                        r.data_byte = 8'h00;
                        r.frame_opcode = op;
                        r.last_of_frame = 1'b1;
                        r.now_closed = (op == OP_CLOSE);
                        got = 1'b1;
                    end
                    else
                        ph = PH_DATA;
                end
            end
            PH_DATA:
            begin
                kb = 8'(key >> ((3 - key_pos) * 8));
                key_pos = key_pos + 2'd1;
                remaining = remaining - 64'd1;
                r.kind = KIND_DATA;
                r.data_byte = b ^ kb;
                r.frame_opcode = op;
                r.last_of_frame = (remaining == 64'd0);
                r.now_closed = 1'b0;
                if (remaining == 64'd0)
                begin
                    ph = PH_HDR0;
                    if (op == OP_CLOSE)
                    begin
                        closed = 1'b1;
                        r.now_closed = 1'b1;
                    end
                end
                got = 1'b1;
            end
            default:
            begin
                op = b[3:0];
                ph = PH_HDR1;
            end
        endcase
    endtask

    // Queue one frame; an unmasked frame stops after its length since the block closes there.
    task automatic add_frame(input logic [3:0] opc, input bit with_mask, input int unsigned len,
                             input len_form_t form, input logic [31:0] k);
        logic [63:0] len64;
        len64 = 64'(len);
        queue_link_byte({4'($urandom), opc});
        case (form)
            FORM_EXT16:
            begin
                queue_link_byte({with_mask, LEN_EXT16});
                queue_link_byte(len64[15:8]);
                queue_link_byte(len64[7:0]);
            end
            FORM_EXT64:
            begin
                queue_link_byte({with_mask, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    queue_link_byte(len64[i*8 +: 8]);
            end
            default:
                queue_link_byte({with_mask, 7'(len)});
        endcase
        if (with_mask)
        begin
            for (int i = 3; i >= 0; i--)
                queue_link_byte(k[i*8 +: 8]);
            for (int i = 0; i < len; i++)
                queue_link_byte(8'($urandom));
        end
        frames_built++;
    endtask

    // Sender: hold a word until taken, then idle in bursts or advance.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || byte_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(7, 0) == 0)
            begin
                gap_left <= $urandom_range(7, 0);
                in_valid <= 1'b0;
            end
            else if (link_bytes.size() != 0)
            begin
                in_byte <= link_bytes.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!long_hold_done && results_checked >= LONG_HOLD_AFTER)
        begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(7, 0) == 0)
        begin
            hold_left <= $urandom_range(7, 0);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Check the result first, then predict from the byte taken at the same edge.
    always @(posedge clk)
    begin
        result_t due;
        result_t want;
        bit      got;
        if (!rst_n)
            byte_taken <= 1'b0;
        else
        begin
            byte_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: kind %0d data_byte %02h opcode %0h",
                           kind, data_byte, frame_opcode);
                    fail_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    results_checked++;
                    case (due.kind)
                        KIND_DATA:  payload_seen++;
                        KIND_EMPTY: empty_seen++;
                        default:    viol_seen++;
                    endcase
                    if (kind !== due.kind)
                    begin
                        $error("kind: expected %0d, got %0d", due.kind, kind);
                        fail_count++;
                    end
                    if (data_byte !== due.data_byte)
                    begin
                        $error("data_byte: expected %02h, got %02h", due.data_byte, data_byte);
                        fail_count++;
                    end
                    if (frame_opcode !== due.frame_opcode)
                    begin
                        $error("frame_opcode: expected %0h, got %0h",
                               due.frame_opcode, frame_opcode);
                        fail_count++;
                    end
                    if (last_of_frame !== due.last_of_frame)
                    begin
                        $error("last_of_frame: expected %0b, got %0b",
                               due.last_of_frame, last_of_frame);
                        fail_count++;
                    end
                    if (now_closed !== due.now_closed)
                    begin
                        $error("now_closed: expected %0b, got %0b", due.now_closed, now_closed);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                deframe_byte(in_byte, got, want);
                if (got)
                    results_due = {results_due, want};
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [3:0]  opc;
        int unsigned len;
        int unsigned pick;
        len_form_t   form;

        // directed: empty frame with opcode F, ping with all-ones key,
        // non-minimal 16-bit length
        add_frame(4'hF, 1'b1, 0, FORM_SHORT, 32'h0000_0000);
        add_frame(4'h9, 1'b1, 2, FORM_SHORT, 32'hFFFF_FFFF);
        add_frame(4'h0, 1'b1, 3, FORM_EXT16, 32'h1234_5678);

        while (link_bytes.size() < LINK_BYTES_WANTED)
        begin
            do
                opc = 4'($urandom);
            while (opc == OP_CLOSE);
            pick = $urandom_range(9, 0);
            form = (pick < 6) ? FORM_SHORT : (pick < 8) ? FORM_EXT16 : FORM_EXT64;
            if ($urandom_range(19, 0) == 0)
                len = (form == FORM_SHORT) ? $urandom_range(125, 13) : $urandom_range(300, 126);
            else
                len = $urandom_range(12, 0);
            add_frame(opc, 1'b1, len, form, $urandom);
        end

        // the block closes only once per run, so pick one way to end it
        case ($urandom_range(4, 0))
            0:
            begin
                ending_name = "close frame with payload";
                add_frame(OP_CLOSE, 1'b1, $urandom_range(5, 1), FORM_SHORT, $urandom);
            end
            1:
            begin
                ending_name = "empty close frame";
                add_frame(OP_CLOSE, 1'b1, 0, FORM_SHORT, $urandom);
            end
            2:
            begin
                ending_name = "unmasked frame, 7-bit length";
                add_frame(4'($urandom), 1'b0, $urandom_range(125, 0), FORM_SHORT, 32'd0);
            end
            3:
            begin
                ending_name = "unmasked frame, 16-bit length";
                add_frame(4'($urandom), 1'b0, $urandom_range(300, 0), FORM_EXT16, 32'd0);
            end
            default:
            begin
                ending_name = "unmasked frame, 64-bit length";
                add_frame(4'($urandom), 1'b0, $urandom_range(300, 0), FORM_EXT64, 32'd0);
            end
        endcase
        // these must all be dropped
        repeat (12)
            queue_link_byte(8'($urandom));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (link_bytes.size() < CALM_TAIL_BYTES);
        calm = 1'b1;

        do
        begin
            @(posedge clk);
            #1;
        end
        while (link_bytes.size() != 0 || in_valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d frames ending with %s; checked %0d results:", frames_built,
                 ending_name, results_checked);
        $display("  %0d payload bytes, %0d empty frames, %0d violations, long output hold-off %0s",
                 payload_seen, empty_seen, viol_seen, long_hold_done ? "done" : "missed");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
